>>> rtl/stmx_pkg.sv
// Shared types, constants and lookup tables of the stem fader, mute and solo mixer.
package stmx_pkg;

    // Field widths
    localparam int RAW_W   = 12;
    localparam int GAIN_W  = 9;
    localparam int MASK_W  = 4;
    localparam int STEMS   = 4;
    localparam int PTR_W   = 2;
    localparam int TIME_W  = 32;
    localparam int HOLD_W  = 16;
    localparam int TOL_W   = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Divider: |raw - bottom| * 256 needs RAW_W + 8 bits
    localparam int DIV_W   = RAW_W + 8;
    localparam int DCNT_W  = $clog2(DIV_W + 1);

    // Ladder table
    localparam int TAB_SLOTS = 16;
    localparam int TAB_IDX_W = $clog2(TAB_SLOTS);
    localparam int ENT_W     = TAB_IDX_W + 1;
    localparam int MATCH_ENTRIES_DEF = 10;

    // Gain constants
    localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(256);

    // Register reset values
    localparam logic [RAW_W-1:0]  RST_FADER_BOTTOM = RAW_W'(120);
    localparam logic [RAW_W-1:0]  RST_FADER_TOP    = RAW_W'(3100);
    localparam logic [HOLD_W-1:0] RST_HOLD_TIME    = HOLD_W'(250);
    localparam logic [RAW_W-1:0]  RST_IDLE_FLOOR   = RAW_W'(120);
    localparam logic [TOL_W-1:0]  RST_TOLERANCE    = TOL_W'(50);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FADER_BOTTOM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FADER_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_FLOOR   = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = CFG_IDX_W'(4);

    typedef logic [GAIN_W-1:0] t_gain;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUSY,
        ST_DONE
    } t_state;

    // Ladder level for each button combination; unused slots are zero
    function automatic logic [RAW_W-1:0] lad_level(input logic [TAB_IDX_W-1:0] idx);
        logic [RAW_W-1:0] lv;
        case (idx)
            4'd0:    lv = RAW_W'(207);
            4'd1:    lv = RAW_W'(401);
            4'd2:    lv = RAW_W'(576);
            4'd3:    lv = RAW_W'(725);
            4'd4:    lv = RAW_W'(860);
            4'd5:    lv = RAW_W'(981);
            4'd6:    lv = RAW_W'(1211);
            4'd7:    lv = RAW_W'(1307);
            4'd8:    lv = RAW_W'(1390);
            4'd9:    lv = RAW_W'(1547);
            default: lv = '0;
        endcase
        return lv;
    endfunction

    // Held-stem mask for each ladder slot
    function automatic logic [MASK_W-1:0] lad_mask(input logic [TAB_IDX_W-1:0] idx);
        logic [MASK_W-1:0] m;
        case (idx)
            4'd0:    m = 4'h1;
            4'd1:    m = 4'h2;
            4'd2:    m = 4'h3;
            4'd3:    m = 4'h4;
            4'd4:    m = 4'h5;
            4'd5:    m = 4'h6;
            4'd6:    m = 4'h8;
            4'd7:    m = 4'h9;
            4'd8:    m = 4'hA;
            4'd9:    m = 4'hC;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

>>> rtl/stem_fader_mute_solo_mixer.sv
// Top level of the stem fader, mute and solo mixer.
// One request per UI tick: the fader sample of the pointer's fader, the button ladder
// level and a millisecond time. From its accepting edge, each request passes through
// the bit-serial restoring divider that scales the fader sample, a step that hands the
// finished quotient over, and a step that updates the mute and solo state and loads the
// result. The input opens again in the cycle after that, so a new request is not taken
// until the previous one has loaded its result. The ladder is matched one table entry
// per cycle alongside the divider. The result sits in an output register, so the next
// request is taken while it waits; that request then holds in its last cycle until the
// waiting result has gone. Configuration is written through a plain write port
// while the block is idle; the user must keep to this, the block does not enforce it.
module stem_fader_mute_solo_mixer
    import stmx_pkg::*;
#(
    parameter int MATCH_ENTRIES = MATCH_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [RAW_W-1:0]     i_fader_level,
    input  logic                 i_fader_valid,
    input  logic [RAW_W-1:0]     i_ladder_level,
    input  logic [TIME_W-1:0]    i_now_ms,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [GAIN_W-1:0]    o_gain_stem0,
    output logic [GAIN_W-1:0]    o_gain_stem1,
    output logic [GAIN_W-1:0]    o_gain_stem2,
    output logic [GAIN_W-1:0]    o_gain_stem3,
    output logic [PTR_W-1:0]     o_next_fader,
    output logic [MASK_W-1:0]    o_solo_mask,
    output logic [MASK_W-1:0]    o_muted_mask,
    output logic [MASK_W-1:0]    o_held_mask
);

    // Configuration registers
    logic [RAW_W-1:0]  r_fader_bottom;
    logic [RAW_W-1:0]  r_fader_top;
    logic [HOLD_W-1:0] r_hold_time;
    logic [RAW_W-1:0]  r_idle_floor;
    logic [TOL_W-1:0]  r_tolerance;

    // Control and mixer state
    t_state            r_state, n_state;
    t_gain             r_fader_gain [STEMS];
    logic [PTR_W-1:0]  r_ptr;
    logic              r_buttons_down;
    logic              r_hold_soloing;
    logic [MASK_W-1:0] r_last_held;
    logic [TIME_W-1:0] r_press_start;
    logic [MASK_W-1:0] r_mute_set;
    logic [MASK_W-1:0] r_solo_set;
    logic              r_out_valid;

    // Captured request and serial datapath
    logic              r_smp_valid;
    logic              r_den_zero;
    logic              r_neg;
    logic [TIME_W-1:0] r_now;
    logic [RAW_W-1:0]  r_lad;
    logic [DIV_W-1:0]  r_num;
    logic [RAW_W-1:0]  r_den;
    logic [RAW_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic [ENT_W-1:0]  r_ent;
    logic              r_match_done;
    logic [MASK_W-1:0] r_cur;

    // Result payload
    t_gain             r_out_gain [STEMS];
    logic [PTR_W-1:0]  r_out_ptr;
    logic [MASK_W-1:0] r_out_solo;
    logic [MASK_W-1:0] r_out_mute;
    logic [MASK_W-1:0] r_out_held;

    // FSM outputs
    logic              in_acc;
    logic              commit;
    logic              out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_BUSY;
            ST_BUSY: if (r_cnt == '0 && r_match_done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_stall = 1'b1;
        in_acc     = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                in_acc     = i_in_valid;
            end
            ST_BUSY: begin
                o_in_stall = 1'b1;
            end
            ST_DONE: begin
                commit = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // Signed numerator and denominator of the fader scaling
    logic [RAW_W:0] num_s;
    logic [RAW_W:0] den_s;
    logic [RAW_W:0] num_abs;
    logic [RAW_W:0] den_abs;

    always_comb begin
        num_s   = {1'b0, i_fader_level} - {1'b0, r_fader_bottom};
        den_s   = {1'b0, r_fader_top} - {1'b0, r_fader_bottom};
        num_abs = num_s[RAW_W] ? (~num_s + 1'b1) : num_s;
        den_abs = den_s[RAW_W] ? (~den_s + 1'b1) : den_s;
    end

    // Divider step: one quotient bit a cycle
    logic [RAW_W:0] div_sh;
    logic [RAW_W:0] div_diff;
    logic           div_ge;

    always_comb begin
        div_sh   = {r_rem, r_num[DIV_W-1]};
        div_diff = div_sh - {1'b0, r_den};
        div_ge   = div_sh >= {1'b0, r_den};
    end

    // Ladder match step: one table entry a cycle
    logic [RAW_W-1:0] tab_lv;
    logic [RAW_W-1:0] lad_dist;
    logic             ent_end;

    always_comb begin
        tab_lv   = lad_level(r_ent[TAB_IDX_W-1:0]);
        lad_dist = (r_lad >= tab_lv) ? (r_lad - tab_lv) : (tab_lv - r_lad);
        ent_end  = (r_ent == ENT_W'(MATCH_ENTRIES));
    end

    // State update and result of one tick
    t_gain             n_fader_gain [STEMS];
    t_gain             n_out_gain [STEMS];
    t_gain             gain_new;
    logic [PTR_W-1:0]  n_ptr;
    logic              n_buttons_down;
    logic              n_hold_soloing;
    logic [MASK_W-1:0] n_last_held;
    logic [TIME_W-1:0] n_press_start;
    logic [MASK_W-1:0] n_mute_set;
    logic [MASK_W-1:0] n_solo_set;
    logic [TIME_W-1:0] press_age;

    always_comb begin
        // scaled gain, clamped to 0..256
        if (r_neg)
            gain_new = '0;
        else if (r_num > DIV_W'(GAIN_UNITY))
            gain_new = GAIN_UNITY;
        else
            gain_new = r_num[GAIN_W-1:0];

        for (int s = 0; s < STEMS; s++) begin
            n_fader_gain[s] = r_fader_gain[s];
        end
        if (r_smp_valid && !r_den_zero)
            n_fader_gain[r_ptr] = gain_new;
        n_ptr = r_ptr + 1'b1;

        // buttons: tap toggles mute, long hold solos
        n_buttons_down = r_buttons_down;
        n_hold_soloing = r_hold_soloing;
        n_last_held    = r_last_held;
        n_press_start  = r_press_start;
        n_mute_set     = r_mute_set;
        n_solo_set     = r_solo_set;
        press_age      = '0;
        if (r_cur != '0) begin
            if (!r_buttons_down) begin
                n_press_start  = r_now;
                n_hold_soloing = 1'b0;
                n_buttons_down = 1'b1;
            end
            n_last_held = r_cur;
            press_age   = r_now - n_press_start;
            if (!n_hold_soloing && press_age > TIME_W'(r_hold_time))
                n_hold_soloing = 1'b1;
            if (n_hold_soloing)
                n_solo_set = r_cur;
        end else if (r_buttons_down) begin
            if (r_hold_soloing)
                n_solo_set = '0;
            else
                n_mute_set = r_mute_set ^ r_last_held;
            n_buttons_down = 1'b0;
        end

        // effective gains: solo wins over mute
        for (int s = 0; s < STEMS; s++) begin
            if (n_solo_set != '0)
                n_out_gain[s] = n_solo_set[s] ? n_fader_gain[s] : '0;
            else
                n_out_gain[s] = n_mute_set[s] ? '0 : n_fader_gain[s];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_fader_bottom <= RST_FADER_BOTTOM;
            r_fader_top    <= RST_FADER_TOP;
            r_hold_time    <= RST_HOLD_TIME;
            r_idle_floor   <= RST_IDLE_FLOOR;
            r_tolerance    <= RST_TOLERANCE;
            for (int s = 0; s < STEMS; s++) begin
                r_fader_gain[s] <= GAIN_UNITY;
            end
            r_ptr          <= '0;
            r_buttons_down <= 1'b0;
            r_hold_soloing <= 1'b0;
            r_last_held    <= '0;
            r_press_start  <= '0;
            r_mute_set     <= '0;
            r_solo_set     <= '0;
            r_out_valid    <= 1'b0;
            r_cnt          <= '0;
            r_match_done   <= 1'b1;
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_FADER_BOTTOM: r_fader_bottom <= i_cfg_data[RAW_W-1:0];
                    CFG_FADER_TOP:    r_fader_top    <= i_cfg_data[RAW_W-1:0];
                    CFG_HOLD_TIME:    r_hold_time    <= i_cfg_data[HOLD_W-1:0];
                    CFG_IDLE_FLOOR:   r_idle_floor   <= i_cfg_data[RAW_W-1:0];
                    CFG_TOLERANCE:    r_tolerance    <= i_cfg_data[TOL_W-1:0];
                    default: ;
                endcase
            end

            // divider count and match progress
            if (in_acc) begin
                r_cnt        <= DCNT_W'(DIV_W);
                r_match_done <= (i_ladder_level < r_idle_floor);
            end else begin
                if (r_cnt != '0)
                    r_cnt <= r_cnt - 1'b1;
                if (!r_match_done && (ent_end || lad_dist <= RAW_W'(r_tolerance)))
                    r_match_done <= 1'b1;
            end

            // state commit
            if (commit) begin
                for (int s = 0; s < STEMS; s++) begin
                    r_fader_gain[s] <= n_fader_gain[s];
                end
                r_ptr          <= n_ptr;
                r_buttons_down <= n_buttons_down;
                r_hold_soloing <= n_hold_soloing;
                r_last_held    <= n_last_held;
                r_press_start  <= n_press_start;
                r_mute_set     <= n_mute_set;
                r_solo_set     <= n_solo_set;
            end

            // output register
            if (commit)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_smp_valid <= i_fader_valid;
            r_den_zero  <= (den_s == '0);
            r_neg       <= num_s[RAW_W] ^ den_s[RAW_W];
            r_now       <= i_now_ms;
            r_lad       <= i_ladder_level;
            r_num       <= {num_abs[RAW_W-1:0], 8'h00};
            r_den       <= den_abs[RAW_W-1:0];
            r_rem       <= '0;
            r_ent       <= '0;
            r_cur       <= '0;
        end else begin
            if (r_cnt != '0) begin
                r_rem <= div_ge ? div_diff[RAW_W-1:0] : div_sh[RAW_W-1:0];
                r_num <= {r_num[DIV_W-2:0], div_ge};
            end
            if (!r_match_done) begin
                if (ent_end)
                    r_cur <= '0;
                else if (lad_dist <= RAW_W'(r_tolerance))
                    r_cur <= lad_mask(r_ent[TAB_IDX_W-1:0]);
                else
                    r_ent <= r_ent + 1'b1;
            end
        end

        if (commit) begin
            for (int s = 0; s < STEMS; s++) begin
                r_out_gain[s] <= n_out_gain[s];
            end
            r_out_ptr  <= n_ptr;
            r_out_solo <= n_solo_set;
            r_out_mute <= n_mute_set;
            r_out_held <= r_cur;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_gain_stem0 = r_out_gain[0];
    assign o_gain_stem1 = r_out_gain[1];
    assign o_gain_stem2 = r_out_gain[2];
    assign o_gain_stem3 = r_out_gain[3];
    assign o_next_fader = r_out_ptr;
    assign o_solo_mask  = r_out_solo;
    assign o_muted_mask = r_out_mute;
    assign o_held_mask  = r_out_held;

endmodule
